// ===== src/dtet_pkg.sv =====
package dtet_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W = 7;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TAKE   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        owner_handle;
    logic signed [31:0] due_time;
    logic signed [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [15:0]            found_handle;
    logic signed [31:0]     found_time;
    logic                   dirty;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] due;
  } entry_t;

endpackage

// ===== src/due_timer_event_table.sv =====
// Sequence: add and unused codes go straight to the result register; remove and take
//   first scan the N held entries through the one memory read port, then compact the
//   entries after a hit, then load the result register.
// Throughput: one item at a time; a new item is taken only when the block is idle.
// Reset: synchronous, active low; clears entry count, dirty flag and control state.
//   Table memory is not cleared; only entries below the count are ever read.
module due_timer_event_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtet_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtet_pkg::out_item_t out_data
);
  import dtet_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  // Entry storage
  entry_t entry_mem [TABLE_DEPTH];
  entry_t rd_data_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               dirty_r, dirty_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        handle_r, handle_nxt;
  logic signed [31:0] now_r, now_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic [15:0]        pick_handle_r, pick_handle_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic               found_r, found_nxt;
  logic               ovf_r, ovf_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_acc;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               sweep_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Scan or shift sweep finished: all reads issued and last one consumed
  assign sweep_done = !pend_r && (issue_r == count_r);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    dirty_nxt       = dirty_r;
    out_valid_nxt   = out_valid_r;
    pend_nxt        = 1'b0;
    pend_idx_nxt    = pend_idx_r;
    issue_nxt       = issue_r;
    op_nxt          = op_r;
    handle_nxt      = handle_r;
    now_nxt         = now_r;
    hit_nxt         = hit_r;
    pick_nxt        = pick_r;
    pick_handle_nxt = pick_handle_r;
    best_nxt        = best_r;
    found_nxt       = found_r;
    ovf_nxt         = ovf_r;
    out_nxt         = out_r;
    rd_en           = 1'b0;
    rd_addr         = issue_r[IDX_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = count_r[IDX_W-1:0];
    wr_data         = rd_data_r;

    // Result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_data.op;
          handle_nxt = in_data.owner_handle;
          now_nxt    = in_data.current_time;
          found_nxt  = 1'b0;
          ovf_nxt    = 1'b0;
          hit_nxt    = 1'b0;
          issue_nxt  = '0;
          best_nxt   = in_data.current_time;
          unique case (in_data.op) inside
            OP_ADD: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = count_r[IDX_W-1:0];
                wr_data.handle = in_data.owner_handle;
                wr_data.due    = in_data.due_time;
                count_nxt      = count_r + CNT_W'(1);
                if (in_data.due_time <= in_data.current_time) begin
                  dirty_nxt = 1'b1;
                end
              end
              state_nxt = ST_RESP;
            end
            OP_REMOVE, OP_TAKE: state_nxt = ST_SCAN;
            default:            state_nxt = ST_RESP;
          endcase
        end
      end

      ST_SCAN: begin
        // issue next read
        if (issue_r < count_r) begin
          rd_en        = 1'b1;
          issue_nxt    = issue_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
        end
        // evaluate returned entry
        if (pend_r) begin
          if (op_r == OP_REMOVE) begin
            // keep the newest match
            if (rd_data_r.handle == handle_r) begin
              hit_nxt  = 1'b1;
              pick_nxt = pend_idx_r;
            end
          end else if ((rd_data_r.due <= now_r) && (!hit_r || (rd_data_r.due < best_r))) begin
            // earliest due, oldest wins ties
            hit_nxt         = 1'b1;
            pick_nxt        = pend_idx_r;
            best_nxt        = rd_data_r.due;
            pick_handle_nxt = rd_data_r.handle;
          end
        end
        if (sweep_done) begin
          if (hit_r) begin
            found_nxt = 1'b1;
            issue_nxt = CNT_W'(pick_r) + CNT_W'(1);
            state_nxt = ST_SHIFT;
          end else begin
            if (op_r == OP_TAKE) begin
              dirty_nxt = 1'b0;
            end
            state_nxt = ST_RESP;
          end
        end
      end

      ST_SHIFT: begin
        // move each later entry down by one place
        if (issue_r < count_r) begin
          rd_en        = 1'b1;
          issue_nxt    = issue_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r - IDX_W'(1);
          wr_data = rd_data_r;
        end
        if (sweep_done) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.found        = found_r;
          out_nxt.found_handle = (found_r && op_r == OP_TAKE) ? pick_handle_r : 16'd0;
          out_nxt.found_time   = (found_r && op_r == OP_TAKE) ? best_r : 32'sd0;
          out_nxt.dirty        = dirty_r;
          out_nxt.overflow     = ovf_r;
          out_nxt.entry_count  = COUNT_OUT_W'(count_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pend_idx_r    <= pend_idx_nxt;
    issue_r       <= issue_nxt;
    op_r          <= op_nxt;
    handle_r      <= handle_nxt;
    now_r         <= now_nxt;
    hit_r         <= hit_nxt;
    pick_r        <= pick_nxt;
    pick_handle_r <= pick_handle_nxt;
    best_r        <= best_nxt;
    found_r       <= found_nxt;
    ovf_r         <= ovf_nxt;
    out_r         <= out_nxt;
  end

  // Held count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Compaction never reads and writes the same entry in one cycle
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write collide on one entry");

  // Count holds steady during a scan
  a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(count_r))
    else $error("entry count changed during scan");

endmodule

// ===== tb/due_timer_event_table_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the event table, keeps its own copy of the table,
// and compares every result transfer against the oldest prediction.
module due_timer_event_table_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dtet_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dtet_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  items_seen,
  output int                  takes_hit,
  output int                  removes_hit,
  output int                  adds_dropped
);
  import dtet_pkg::*;

  // Shadow table, oldest entry at index 0
  logic [15:0]        shadow_handle [TABLE_DEPTH];
  logic signed [31:0] shadow_due    [TABLE_DEPTH];
  int                 shadow_count;
  bit                 shadow_dirty;

  out_item_t result_q [$];

  // Close the gap at pos, keeping order
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_handle[i] = shadow_handle[i + 1];
      shadow_due[i]    = shadow_due[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one item to the shadow table and return the result it should give
  function automatic out_item_t apply_item(in_item_t item);
    out_item_t          res;
    logic signed [31:0] best;
    int                 pick;
    bit                 hit;
    res  = '0;
    best = item.current_time;
    pick = 0;
    hit  = 1'b0;
    case (item.op)
      OP_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          shadow_handle[shadow_count] = item.owner_handle;
          shadow_due[shadow_count]    = item.due_time;
          shadow_count++;
          if (item.due_time <= item.current_time) shadow_dirty = 1'b1;
        end
      end
      OP_REMOVE: begin
        // newest matching handle goes first
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_handle[i] == item.owner_handle) begin
            drop_entry(i);
            res.found = 1'b1;
            break;
          end
        end
      end
      OP_TAKE: begin
        // scan newest to oldest with <=, so ties land on the oldest entry
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_due[i] <= best) begin
            best = shadow_due[i];
            pick = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          res.found        = 1'b1;
          res.found_handle = shadow_handle[pick];
          res.found_time   = shadow_due[pick];
          drop_entry(pick);
        end else begin
          shadow_dirty = 1'b0;
        end
      end
      default: ;
    endcase
    res.dirty       = shadow_dirty;
    res.entry_count = COUNT_OUT_W'(shadow_count);
    return res;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result transfers are checked first: none can stem from an item taken at the same edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_dirty = 1'b0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (result_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("found", want.found, got.found);
          check_field("found_handle", want.found_handle, got.found_handle);
          check_field("found_time", want.found_time, got.found_time);
          check_field("dirty", want.dirty, got.dirty);
          check_field("overflow", want.overflow, got.overflow);
          check_field("entry_count", want.entry_count, got.entry_count);
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_item(in_data);
        result_q.push_back(want);
        items_seen++;
        if (in_data.op == OP_TAKE && want.found) takes_hit++;
        if (in_data.op == OP_REMOVE && want.found) removes_hit++;
        if (want.overflow) adds_dropped++;
      end
    end
    pending_count = result_q.size();
  end

endmodule

// ===== tb/due_timer_event_table_tb.sv =====
`timescale 1ns / 100ps

module due_timer_event_table_tb;
  import dtet_pkg::*;

  localparam logic [1:0]         OP_UNUSED    = 2'd3;
  localparam logic signed [31:0] T_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX        = 32'sh7FFF_FFFF;
  localparam int                 ITEM_TARGET  = 1900;
  localparam int                 DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int                 CYCLE_LIMIT  = 1_500_000;
  localparam int                 HOLD_CYCLES  = 600;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending_count;
  int items_seen;
  int takes_hit;
  int removes_hit;
  int adds_dropped;
  int cycle_count;
  int items_sent;

  // both sides skip idling while set
  bit                 steady;
  logic signed [31:0] tick_now;
  logic [15:0]        handle_pool [8];

  due_timer_event_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  due_timer_event_table_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .items_seen   (items_seen),
    .takes_hit    (takes_hit),
    .removes_hit  (removes_hit),
    .adds_dropped (adds_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_item_t compose(logic [1:0] op, logic [15:0] handle,
                                       logic signed [31:0] due,
                                       logic signed [31:0] now);
    in_item_t item;
    item.op           = op;
    item.owner_handle = handle;
    item.due_time     = due;
    item.current_time = now;
    return item;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic push_item(in_item_t item);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Mostly handles from a small pool so removes find matches
  function automatic logic [15:0] pick_handle();
    if ($urandom_range(0, 9) < 8) return handle_pool[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] pick_op(phase_t kind);
    int roll;
    int add_cut;
    int remove_cut;
    int take_cut;
    roll = $urandom_range(0, 99);
    case (kind)
      PH_FILL:  begin add_cut = 85; remove_cut = 90; take_cut = 97; end
      PH_DRAIN: begin add_cut = 20; remove_cut = 50; take_cut = 95; end
      default:  begin add_cut = 45; remove_cut = 65; take_cut = 95; end
    endcase
    if (roll < add_cut) return OP_ADD;
    if (roll < remove_cut) return OP_REMOVE;
    if (roll < take_cut) return OP_TAKE;
    return OP_UNUSED;
  endfunction

  // Times track a slowly advancing clock, with occasional wild values
  function automatic in_item_t random_item(phase_t kind);
    in_item_t item;
    int       offset;
    tick_now = tick_now + 32'($urandom_range(0, 4));
    offset   = int'($urandom_range(0, 60)) - 20;
    item.op           = pick_op(kind);
    item.owner_handle = pick_handle();
    item.due_time     = tick_now + offset;
    item.current_time = tick_now;
    if ($urandom_range(0, 15) == 0) item.due_time = 32'($urandom);
    if ($urandom_range(0, 15) == 0) item.current_time = 32'($urandom);
    if ($urandom_range(0, 31) == 0) item.due_time = $urandom_range(0, 1) ? T_MIN : T_MAX;
    if ($urandom_range(0, 63) == 0) item.current_time = $urandom_range(0, 1) ? T_MIN : T_MAX;
    return item;
  endfunction

  // Result side: random stall per result, plus long hold-offs to back up the input
  initial begin
    int results_taken;
    int wait_cycles;
    results_taken = 0;
    out_stall     = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (results_taken == 400 || results_taken == 1300) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      wait_cycles = steady ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      results_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    phase_t kind;
    int     phase_len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    steady     = 1'b0;
    items_sent = 0;
    tick_now   = 32'($urandom);
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) handle_pool[i] = 16'($urandom);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, unused code, extremes, duplicates, ties
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, 32'sd0));
    push_item(compose(OP_REMOVE, 16'h1234, 32'sd0, 32'sd0));
    push_item(compose(OP_UNUSED, 16'hFFFF, T_MAX, T_MAX));
    push_item(compose(OP_ADD, 16'h0000, T_MIN, T_MIN));
    push_item(compose(OP_ADD, 16'hFFFF, T_MAX, T_MIN));
    push_item(compose(OP_ADD, 16'h0005, 32'sd100, 32'sd0));
    push_item(compose(OP_ADD, 16'h0005, 32'sd100, 32'sd200));
    push_item(compose(OP_ADD, 16'h0007, 32'sd100, 32'sd0));
    push_item(compose(OP_ADD, 16'h0007, 32'sd50, 32'sd0));
    push_item(compose(OP_UNUSED, 16'h0000, 32'sd0, 32'sd0));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, T_MIN));
    push_item(compose(OP_REMOVE, 16'h0007, 32'sd0, 32'sd0));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, 32'sd99));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, 32'sd100));
    push_item(compose(OP_REMOVE, 16'h0005, 32'sd0, 32'sd0));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, T_MAX));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, T_MAX));
    push_item(compose(OP_TAKE, 16'h0000, 32'sd0, T_MAX));
    push_item(compose(OP_REMOVE, 16'hFFFF, 32'sd0, 32'sd0));

    // Random phases: fill runs are mostly adds, drain runs mostly removes and takes
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       kind = PH_FILL;
        1:       kind = PH_DRAIN;
        default: kind = PH_MIXED;
      endcase
      phase_len = $urandom_range(40, 120);
      if (phase_len > ITEM_TARGET - items_sent) phase_len = ITEM_TARGET - items_sent;
      steady    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) tick_now = 32'($urandom);
      repeat (phase_len) push_item(random_item(kind));
    end
    steady   = 1'b0;
    in_valid <= 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d items across fill, drain and mixed phases with random idling.",
             items_seen);
    $display("Takes returned %0d entries, removes matched %0d, %0d adds hit a full table.",
             takes_hit, removes_hit, adds_dropped);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
